// ===== hdl/direct_mapped_writeback_cache_assert.svh =====
// Assertion macros used by the cache RTL.
// Depends on nothing; included by the top module, which checks its own logic.
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_ASSERT_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define DMWC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cache assertion failed");

// Next-cycle implication, disabled while reset is held.
`define DMWC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cache assertion failed");

`endif

// ===== hdl/dmwc_pkg.sv =====
// Geometry, codes and request structs of the direct-mapped write-back cache.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package dmwc_pkg;

    localparam int ADDR_BITS   = 16;
    localparam int SET_COUNT   = 64;
    localparam int BLOCK_BYTES = 32;
    localparam int DATA_W      = 32;

    localparam int WPB      = BLOCK_BYTES / 4;
    localparam int OFF_W    = $clog2(WPB);
    localparam int SET_W    = $clog2(SET_COUNT);
    localparam int TAG_W    = ADDR_BITS - 2 - OFF_W - SET_W;
    localparam int MEM_AW   = ADDR_BITS - 2;
    localparam int MEM_WORDS = 1 << MEM_AW;
    localparam int LINE_AW  = SET_W + OFF_W;
    localparam int LINE_WORDS = SET_COUNT * WPB;
    localparam int CNT_W    = $clog2(WPB + 1);
    localparam int IN_DATA_W = ((ADDR_BITS + DATA_W + 7) / 8) * 8;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } t_mem_req;

    typedef struct packed {
        logic               tag_we;
        logic [SET_W-1:0]   set_idx;
        logic [TAG_W-1:0]   tag_wdata;
        logic               data_we;
        logic [LINE_AW-1:0] data_addr;
        logic [DATA_W-1:0]  data_wdata;
    } t_line_req;

endpackage

// ===== hdl/dmwc_backing.sv =====
// Main memory behind the cache: one word-wide synchronous RAM plus the
// clearing sweep that zeroes it after reset. Uses dmwc_pkg.
`timescale 1ns / 1ps
module dmwc_backing (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dmwc_pkg::t_mem_req           i_req,
    output logic [dmwc_pkg::DATA_W-1:0]  o_rdata,
    output logic                         o_busy
);

    logic [dmwc_pkg::DATA_W-1:0] r_mem [dmwc_pkg::MEM_WORDS];
    logic [dmwc_pkg::DATA_W-1:0] r_rdata;
    logic [dmwc_pkg::MEM_AW-1:0] r_clr_addr;
    logic                        r_clearing;

    logic                        w_we;
    logic [dmwc_pkg::MEM_AW-1:0] w_addr;
    logic [dmwc_pkg::DATA_W-1:0] w_wdata;

    always_comb begin
        w_we    = r_clearing | i_req.we;
        w_addr  = r_clearing ? r_clr_addr : i_req.addr;
        w_wdata = r_clearing ? '0 : i_req.wdata;
    end

    // one word per cycle until the whole store reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + dmwc_pkg::MEM_AW'(1);
            if (r_clr_addr == {dmwc_pkg::MEM_AW{1'b1}}) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_wdata;
        end
        r_rdata <= r_mem[w_addr];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clearing;

endmodule

// ===== hdl/dmwc_lines.sv =====
// Tag RAM and line data RAM of the cache, both single-port with a
// registered read. Uses dmwc_pkg for geometry and the request struct.
`timescale 1ns / 1ps
module dmwc_lines (
    input  logic                         i_clk,
    input  dmwc_pkg::t_line_req          i_req,
    output logic [dmwc_pkg::TAG_W-1:0]   o_tag_rdata,
    output logic [dmwc_pkg::DATA_W-1:0]  o_data_rdata
);

    logic [dmwc_pkg::TAG_W-1:0]  r_tag_mem  [dmwc_pkg::SET_COUNT];
    logic [dmwc_pkg::DATA_W-1:0] r_data_mem [dmwc_pkg::LINE_WORDS];
    logic [dmwc_pkg::TAG_W-1:0]  r_tag_rdata;
    logic [dmwc_pkg::DATA_W-1:0] r_data_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.tag_we) begin
            r_tag_mem[i_req.set_idx] <= i_req.tag_wdata;
        end
        r_tag_rdata <= r_tag_mem[i_req.set_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.data_we) begin
            r_data_mem[i_req.data_addr] <= i_req.data_wdata;
        end
        r_data_rdata <= r_data_mem[i_req.data_addr];
    end

    assign o_tag_rdata  = r_tag_rdata;
    assign o_data_rdata = r_data_rdata;

endmodule

// ===== hdl/direct_mapped_writeback_cache.sv =====
// Direct-mapped, write-back, write-allocate cache with its main memory.
// Holds the access sequencer and per-set valid/dirty bits; uses dmwc_pkg,
// dmwc_lines, dmwc_backing and the assertion macro header.
//
// Usage:
//   Slave stream carries one word request: tuser[0] is the access kind
//   (0 read, 1 write), tdata holds the byte address (low two bits ignored)
//   and above it the write word. Master stream returns one result per
//   request: tdata is the read word (zero for a write), tuser[0] the miss
//   flag and tuser[1] the writeback flag.
//   A hit returns its result from S_LOOKUP, and the next request can be
//   taken right after once the output register is free; the tag/data RAM
//   read-then-update sets the pace of hits. A clean miss fills the 8 words
//   of the line through the single main memory port, a dirty miss first
//   writes back the old line ahead of the fill.
//   After reset all lines are invalid and main memory is swept to zero,
//   one word a cycle: s_axis_tready stays low until the sweep ends.
//   Results sit in an output register; a new request is taken while it
//   waits, and only the finish of that request waits for m_axis_tready.
`timescale 1ns / 1ps
`include "direct_mapped_writeback_cache_assert.svh"
module direct_mapped_writeback_cache (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [dmwc_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // address, write_data
    input  logic [0:0]                         s_axis_tuser,  // action
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [dmwc_pkg::DATA_W-1:0]        m_axis_tdata,  // read_data
    output logic [1:0]                         m_axis_tuser   // miss, wrote_back
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_WB,
        S_FILL,
        S_DONE
    } t_state;

    localparam int OFF_LO = 2;
    localparam int SET_LO = OFF_LO + dmwc_pkg::OFF_W;
    localparam int TAG_LO = SET_LO + dmwc_pkg::SET_W;

    t_state                          r_state;
    logic                            r_act;
    logic [dmwc_pkg::TAG_W-1:0]      r_tag;
    logic [dmwc_pkg::SET_W-1:0]      r_set;
    logic [dmwc_pkg::OFF_W-1:0]      r_word;
    logic [dmwc_pkg::DATA_W-1:0]     r_wdata;
    logic [dmwc_pkg::TAG_W-1:0]      r_old_tag;
    logic [dmwc_pkg::CNT_W-1:0]      r_cnt;
    logic [dmwc_pkg::SET_COUNT-1:0]  r_valid;
    logic [dmwc_pkg::SET_COUNT-1:0]  r_dirty;
    logic [dmwc_pkg::DATA_W-1:0]     r_res_data;
    logic                            r_res_miss;
    logic                            r_res_wb;
    logic                            r_out_valid;
    logic [dmwc_pkg::DATA_W-1:0]     r_out_data;
    logic [1:0]                      r_out_user;

    dmwc_pkg::t_mem_req              w_bk_req;
    dmwc_pkg::t_line_req             w_ln_req;
    logic [dmwc_pkg::DATA_W-1:0]     w_bk_rdata;
    logic                            w_bk_busy;
    logic [dmwc_pkg::TAG_W-1:0]      w_tag_rdata;
    logic [dmwc_pkg::DATA_W-1:0]     w_data_rdata;

    logic [dmwc_pkg::ADDR_BITS-1:0]  w_in_addr;
    logic                            w_accept;
    logic                            w_hit;
    logic                            w_out_free;
    logic                            w_load;
    logic [dmwc_pkg::DATA_W-1:0]     w_load_data;
    logic [1:0]                      w_load_user;
    logic [dmwc_pkg::CNT_W-1:0]      w_cnt_dec;
    logic [dmwc_pkg::OFF_W-1:0]      w_prev_word;
    logic                            w_cnt_end;
    logic                            w_is_write;

    dmwc_lines u_lines (
        .i_clk        (i_clk),
        .i_req        (w_ln_req),
        .o_tag_rdata  (w_tag_rdata),
        .o_data_rdata (w_data_rdata)
    );

    dmwc_backing u_backing (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_bk_req),
        .o_rdata (w_bk_rdata),
        .o_busy  (w_bk_busy)
    );

    always_comb begin
        w_in_addr   = s_axis_tdata[dmwc_pkg::ADDR_BITS-1:0];
        w_accept    = s_axis_tvalid && s_axis_tready;
        w_is_write  = (r_act == dmwc_pkg::ACT_WRITE);
        w_hit       = r_valid[r_set] && (w_tag_rdata == r_tag);
        w_out_free  = !r_out_valid || m_axis_tready;
        w_cnt_dec   = r_cnt - dmwc_pkg::CNT_W'(1);
        w_prev_word = w_cnt_dec[dmwc_pkg::OFF_W-1:0];
        w_cnt_end   = (r_cnt == dmwc_pkg::CNT_W'(dmwc_pkg::WPB));
    end

    // result into the output register: straight from a hit, else from S_DONE
    always_comb begin
        w_load      = 1'b0;
        w_load_data = r_res_data;
        w_load_user = {r_res_wb, r_res_miss};
        if (r_state == S_LOOKUP && w_hit) begin
            w_load      = w_out_free;
            w_load_data = w_is_write ? '0 : w_data_rdata;
            w_load_user = 2'b00;
        end else if (r_state == S_DONE) begin
            w_load = w_out_free;
        end
    end

    // RAM requests per state
    always_comb begin
        w_bk_req            = '0;
        w_ln_req            = '0;
        w_ln_req.set_idx    = r_set;
        w_ln_req.tag_wdata  = r_tag;
        w_ln_req.data_addr  = {r_set, r_word};
        w_ln_req.data_wdata = r_wdata;
        unique case (r_state)
            S_IDLE: begin
                w_ln_req.set_idx   = w_in_addr[SET_LO +: dmwc_pkg::SET_W];
                w_ln_req.data_addr = w_in_addr[OFF_LO +: dmwc_pkg::LINE_AW];
            end
            S_LOOKUP: begin
                w_ln_req.data_we = w_hit && w_is_write;
            end
            S_WB: begin
                // read word cnt, write back the word read the cycle before
                w_ln_req.data_addr = {r_set, r_cnt[dmwc_pkg::OFF_W-1:0]};
                w_bk_req.we        = (r_cnt != '0);
                w_bk_req.addr      = {r_old_tag, r_set, w_prev_word};
                w_bk_req.wdata     = w_data_rdata;
            end
            S_FILL: begin
                w_bk_req.addr      = {r_tag, r_set, r_cnt[dmwc_pkg::OFF_W-1:0]};
                w_ln_req.data_we   = (r_cnt != '0);
                w_ln_req.data_addr = {r_set, w_prev_word};
                w_ln_req.data_wdata = (w_is_write && w_prev_word == r_word) ?
                                      r_wdata : w_bk_rdata;
                w_ln_req.tag_we    = w_cnt_end;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_dirty     <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_out_data  <= w_load_data;
                r_out_user  <= w_load_user;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_act   <= s_axis_tuser[0];
                        r_word  <= w_in_addr[OFF_LO +: dmwc_pkg::OFF_W];
                        r_set   <= w_in_addr[SET_LO +: dmwc_pkg::SET_W];
                        r_tag   <= w_in_addr[TAG_LO +: dmwc_pkg::TAG_W];
                        r_wdata <= s_axis_tdata[dmwc_pkg::ADDR_BITS +: dmwc_pkg::DATA_W];
                        r_state <= S_LOOKUP;
                    end
                end
                S_LOOKUP: begin
                    r_old_tag <= w_tag_rdata;
                    r_cnt     <= '0;
                    if (w_hit) begin
                        if (w_is_write) begin
                            r_dirty[r_set] <= 1'b1;
                        end
                        r_res_data <= w_load_data;
                        r_res_miss <= 1'b0;
                        r_res_wb   <= 1'b0;
                        r_state    <= w_out_free ? S_IDLE : S_DONE;
                    end else begin
                        r_res_miss <= 1'b1;
                        r_res_data <= '0;
                        if (r_valid[r_set] && r_dirty[r_set]) begin
                            r_res_wb <= 1'b1;
                            r_state  <= S_WB;
                        end else begin
                            r_res_wb <= 1'b0;
                            r_state  <= S_FILL;
                        end
                    end
                end
                S_WB: begin
                    if (w_cnt_end) begin
                        r_cnt   <= '0;
                        r_state <= S_FILL;
                    end else begin
                        r_cnt <= r_cnt + dmwc_pkg::CNT_W'(1);
                    end
                end
                S_FILL: begin
                    // catch the requested word as it lands in the line
                    if (r_cnt != '0 && w_prev_word == r_word && !w_is_write) begin
                        r_res_data <= w_bk_rdata;
                    end
                    if (w_cnt_end) begin
                        r_valid[r_set] <= 1'b1;
                        r_dirty[r_set] <= w_is_write;
                        r_state        <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + dmwc_pkg::CNT_W'(1);
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && !w_bk_busy;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    `DMWC_ASSERT_NXT(a_accept_to_lookup, i_clk, i_rst_n, w_accept, r_state == S_LOOKUP)
    `DMWC_ASSERT_IMP(a_load_needs_room, i_clk, i_rst_n, w_load, w_out_free)
    `DMWC_ASSERT_IMP(a_no_wb_while_clear, i_clk, i_rst_n, w_bk_busy, !w_bk_req.we)
    `DMWC_ASSERT_IMP(a_fill_reads_only, i_clk, i_rst_n, r_state == S_FILL, !w_bk_req.we)
    `DMWC_ASSERT_NXT(a_fill_sets_line, i_clk, i_rst_n, r_state == S_FILL && w_cnt_end, r_valid[r_set] && (r_dirty[r_set] == (r_act == dmwc_pkg::ACT_WRITE)))

endmodule
